/* hw/rtl/cau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, pipeline sizing, the arctangent table and the stage record that
// travels through the bit-step pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_SUB   = 3'd1;
	localparam logic [2:0] CMD_MUL   = 3'd2;
	localparam logic [2:0] CMD_DIV   = 3'd3;
	localparam logic [2:0] CMD_MAG   = 3'd4;
	localparam logic [2:0] CMD_PHASE = 3'd5;
	localparam logic [2:0] CMD_NEG   = 3'd6;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int DIV_STEPS = 17;
	localparam int SQRT_STEPS = 16;
	localparam int N_STEPS = (ANGLE_ITERATIONS > DIV_STEPS) ? ANGLE_ITERATIONS : DIV_STEPS;
	localparam int LATENCY = N_STEPS + 4;

	localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [24:0] HALF_PI_Q8 = 25'sd402;

	typedef struct packed {
		logic                vld;
		logic [2:0]          cmd;
		logic signed [24:0]  sre;
		logic signed [24:0]  sim;
		logic                dz;
		logic                neg_re;
		logic                neg_im;
		logic                ov_re;
		logic                ov_im;
		logic                axis;
		logic [32:0]         dd;
		logic [40:0]         rre;
		logic [40:0]         rim;
		logic [15:0]         qre;
		logic [15:0]         qim;
		logic [31:0]         sq_n;
		logic [17:0]         sq_rem;
		logic [15:0]         sq_root;
		logic signed [26:0]  cx;
		logic signed [26:0]  cy;
		logic signed [20:0]  cz;
	} step_t;

	function automatic logic signed [20:0] atan_q16(input int i);
		logic signed [20:0] r;
		case (i)
			0: r = 21'sd51472;
			1: r = 21'sd30386;
			2: r = 21'sd16055;
			3: r = 21'sd8150;
			4: r = 21'sd4091;
			5: r = 21'sd2047;
			6: r = 21'sd1024;
			7: r = 21'sd512;
			8: r = 21'sd256;
			9: r = 21'sd128;
			10: r = 21'sd64;
			11: r = 21'sd32;
			12: r = 21'sd16;
			13: r = 21'sd8;
			14: r = 21'sd4;
			15: r = 21'sd2;
			16: r = 21'sd1;
			default: r = 21'sd0;
		endcase
		return r;
	endfunction

	// Returns the saturation flag above a 16-bit clipped value.
	function automatic logic [16:0] clip16(input logic signed [25:0] v);
		logic [16:0] r;
		if (v > 26'sd32767) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -26'sd32768) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/cau_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: operand products, sums, and setup of the divide, square root
// and angle pipelines.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [2:0]          cmd,
	input  logic signed [15:0]  a_re,
	input  logic signed [15:0]  a_im,
	input  logic signed [15:0]  b_re,
	input  logic signed [15:0]  b_im,
	output cau_pkg::step_t      step_out
);

	logic               vld_s1, vld_s2, vld_s3;
	logic [2:0]         cmd_s1, cmd_s2;
	logic signed [15:0] ar_s1, ai_s1, br_s1, bi_s1, ar_s2, ai_s2;
	logic signed [31:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1, p6_s1, p7_s1;
	logic signed [24:0] sre_s2, sim_s2;
	logic signed [32:0] nre_s2, nim_s2;
	logic [31:0]        den_s2, n_s2;
	cau_pkg::step_t     st_s3;

	logic signed [32:0] t_re, t_im;
	logic signed [24:0] sre_c, sim_c;
	logic [32:0]        mre, mim;
	logic signed [26:0] x0, y0;
	cau_pkg::step_t     st_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		ar_s1 <= a_re;
		ai_s1 <= a_im;
		br_s1 <= b_re;
		bi_s1 <= b_im;
		p0_s1 <= a_re * b_re;
		p1_s1 <= a_im * b_im;
		p2_s1 <= a_re * b_im;
		p3_s1 <= a_im * b_re;
		p4_s1 <= b_re * b_re;
		p5_s1 <= b_im * b_im;
		p6_s1 <= a_re * a_re;
		p7_s1 <= a_im * a_im;
	end

	always_comb begin
		t_re = 33'(p0_s1) - 33'(p1_s1) + 33'sd128;
		t_im = 33'(p2_s1) + 33'(p3_s1) + 33'sd128;
		case (cmd_s1)
			cau_pkg::CMD_ADD: begin
				sre_c = 25'(ar_s1) + 25'(br_s1);
				sim_c = 25'(ai_s1) + 25'(bi_s1);
			end
			cau_pkg::CMD_SUB: begin
				sre_c = 25'(ar_s1) - 25'(br_s1);
				sim_c = 25'(ai_s1) - 25'(bi_s1);
			end
			cau_pkg::CMD_MUL: begin
				sre_c = t_re[32:8];
				sim_c = t_im[32:8];
			end
			cau_pkg::CMD_NEG: begin
				sre_c = -25'(ar_s1);
				sim_c = -25'(ai_s1);
			end
			default: begin
				sre_c = '0;
				sim_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		ar_s2 <= ar_s1;
		ai_s2 <= ai_s1;
		sre_s2 <= sre_c;
		sim_s2 <= sim_c;
		nre_s2 <= 33'(p0_s1) + 33'(p1_s1);
		nim_s2 <= 33'(p3_s1) - 33'(p2_s1);
		den_s2 <= p4_s1[31:0] + p5_s1[31:0];
		n_s2 <= p6_s1[31:0] + p7_s1[31:0];
	end

	always_comb begin
		mre = nre_s2[32] ? 33'(-nre_s2) : 33'(nre_s2);
		mim = nim_s2[32] ? 33'(-nim_s2) : 33'(nim_s2);
		x0 = {{3{ar_s2[15]}}, ar_s2, 8'b0};
		y0 = {{3{ai_s2[15]}}, ai_s2, 8'b0};
		st_c = '0;
		st_c.cmd = cmd_s2;
		st_c.sre = sre_s2;
		st_c.sim = sim_s2;
		st_c.dz = (den_s2 == 32'd0);
		st_c.neg_re = nre_s2[32];
		st_c.neg_im = nim_s2[32];
		st_c.dd = {den_s2, 1'b0};
		st_c.rre = {mre[31:0], 9'b0} + {9'b0, den_s2};
		st_c.rim = {mim[31:0], 9'b0} + {9'b0, den_s2};
		st_c.sq_n = n_s2;
		st_c.axis = (ar_s2 == 16'sd0);
		if (cmd_s2 == cau_pkg::CMD_PHASE) begin
			if (ai_s2 > 16'sd0) begin
				st_c.sre = cau_pkg::HALF_PI_Q8;
			end else if (ai_s2 < 16'sd0) begin
				st_c.sre = -cau_pkg::HALF_PI_Q8;
			end else begin
				st_c.sre = '0;
			end
		end
		st_c.cx = x0;
		st_c.cy = y0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				st_c.cx = y0;
				st_c.cy = -x0;
				st_c.cz = cau_pkg::HALF_PI_Q16;
			end else begin
				st_c.cx = -y0;
				st_c.cy = x0;
				st_c.cz = -cau_pkg::HALF_PI_Q16;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_s3 <= st_c;
	end

	always_comb begin
		step_out = st_s3;
		step_out.vld = vld_s3;
	end

endmodule

/* hw/rtl/cau_iter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit bit-step pipeline
// One quotient bit per stage for both dividers, one root bit per stage for the
// square root, and one vectoring rotation per stage for the angle.
// ----------------------------------------------------------------------------
module cau_iter (
	input  logic            clk,
	input  logic            arst_n,
	input  cau_pkg::step_t  step_in,
	output cau_pkg::step_t  step_out
);

	cau_pkg::step_t st_s [cau_pkg::N_STEPS + 1];

	assign st_s[0] = step_in;

	for (genvar i = 0; i < cau_pkg::N_STEPS; i++) begin : g_step
		cau_pkg::step_t     nx;
		logic [$bits(cau_pkg::step_t) - 2:0] r_s;
		logic               vld_s;
		logic [48:0]        dsh;
		logic [19:0]        rem4, trial;
		logic signed [26:0] xs, ys;

		always_comb begin
			nx = st_s[i];
			dsh = '0;
			rem4 = '0;
			trial = '0;
			xs = '0;
			ys = '0;
			if (i < cau_pkg::DIV_STEPS) begin
				dsh = {16'b0, st_s[i].dd} << (cau_pkg::DIV_STEPS - 1 - i);
				if (i == 0) begin
					nx.ov_re = ({8'b0, st_s[i].rre} >= dsh);
					nx.ov_im = ({8'b0, st_s[i].rim} >= dsh);
				end else begin
					if ({8'b0, st_s[i].rre} >= dsh) begin
						nx.rre = st_s[i].rre - dsh[40:0];
						nx.qre[cau_pkg::DIV_STEPS - 1 - i] = 1'b1;
					end
					if ({8'b0, st_s[i].rim} >= dsh) begin
						nx.rim = st_s[i].rim - dsh[40:0];
						nx.qim[cau_pkg::DIV_STEPS - 1 - i] = 1'b1;
					end
				end
			end
			if (i < cau_pkg::SQRT_STEPS) begin
				rem4 = {st_s[i].sq_rem, st_s[i].sq_n[31:30]};
				trial = {2'b0, st_s[i].sq_root, 2'b01};
				nx.sq_n = {st_s[i].sq_n[29:0], 2'b00};
				if (rem4 >= trial) begin
					nx.sq_rem = 18'(rem4 - trial);
					nx.sq_root = {st_s[i].sq_root[14:0], 1'b1};
				end else begin
					nx.sq_rem = rem4[17:0];
					nx.sq_root = {st_s[i].sq_root[14:0], 1'b0};
				end
			end
			if (i < cau_pkg::ANGLE_ITERATIONS) begin
				xs = st_s[i].cx >>> i;
				ys = st_s[i].cy >>> i;
				if (st_s[i].cy >= 0) begin
					nx.cx = st_s[i].cx + ys;
					nx.cy = st_s[i].cy - xs;
					nx.cz = st_s[i].cz + cau_pkg::atan_q16(i);
				end else begin
					nx.cx = st_s[i].cx - ys;
					nx.cy = st_s[i].cy + xs;
					nx.cz = st_s[i].cz - cau_pkg::atan_q16(i);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= st_s[i].vld;
			end
		end

		always_ff @(posedge clk) begin
			r_s <= nx[$bits(cau_pkg::step_t) - 2:0];
		end

		assign st_s[i + 1] = {vld_s, r_s};
	end

	assign step_out = st_s[cau_pkg::N_STEPS];

endmodule

/* hw/rtl/cau_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Selects the result for the opcode, rounds the root and the angle, applies
// the divide sign and saturates both parts into the output register.
// ----------------------------------------------------------------------------
module cau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cau_pkg::step_t     step_in,
	output logic               done,
	output logic signed [15:0] res_re,
	output logic signed [15:0] res_im,
	output logic               div_zero,
	output logic               saturated
);

	logic signed [25:0] vr, vi;
	logic [16:0]        mq_re, mq_im, root;
	logic signed [20:0] zr;
	logic               dzc;
	logic [16:0]        cr, ci;
	logic               done_q, dz_q, sat_q;
	logic signed [15:0] re_q, im_q;

	always_comb begin
		mq_re = step_in.ov_re ? 17'h10000 : {1'b0, step_in.qre};
		mq_im = step_in.ov_im ? 17'h10000 : {1'b0, step_in.qim};
		root = {1'b0, step_in.sq_root} + 17'({17'b0, step_in.sq_rem} > {19'b0, step_in.sq_root});
		zr = (step_in.cz + 21'sd128) >>> 8;
		vr = '0;
		vi = '0;
		dzc = 1'b0;
		case (step_in.cmd)
			cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL, cau_pkg::CMD_NEG: begin
				vr = 26'(step_in.sre);
				vi = 26'(step_in.sim);
			end
			cau_pkg::CMD_DIV: begin
				if (step_in.dz) begin
					dzc = 1'b1;
				end else begin
					vr = step_in.neg_re ? -26'(mq_re) : 26'(mq_re);
					vi = step_in.neg_im ? -26'(mq_im) : 26'(mq_im);
				end
			end
			cau_pkg::CMD_MAG: begin
				vr = 26'(root);
			end
			cau_pkg::CMD_PHASE: begin
				vr = step_in.axis ? 26'(step_in.sre) : 26'(zr);
			end
			default: begin
				vr = '0;
			end
		endcase
		cr = cau_pkg::clip16(vr);
		ci = cau_pkg::clip16(vi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= step_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		re_q <= cr[15:0];
		im_q <= ci[15:0];
		dz_q <= dzc;
		sat_q <= cr[16] | ci[16];
	end

	assign done = done_q;
	assign res_re = re_q;
	assign res_im = im_q;
	assign div_zero = dz_q;
	assign saturated = sat_q;

endmodule

/* hw/rtl/complex_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// A request is taken on every cycle that start is high; busy is always low.
// Each request returns one result, marked by done for one cycle, after it
// passes three front stages (products, sums, setup), one stage per step of
// the longest bit-serial unit (seventeen divide steps or the angle rotations,
// whichever is more) and one output stage. Results keep request order and
// cannot be held off.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [15:0] a_re,
	input  logic signed [15:0] a_im,
	input  logic signed [15:0] b_re,
	input  logic signed [15:0] b_im,
	output logic               done,
	output logic signed [15:0] res_re,
	output logic signed [15:0] res_im,
	output logic               div_zero,
	output logic               saturated
);

	cau_pkg::step_t front_st, iter_st;

	assign busy = 1'b0;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start & ~busy),
		.cmd      (cmd),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.step_out (front_st)
	);

	cau_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_in  (front_st),
		.step_out (iter_st)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_in   (iter_st),
		.done      (done),
		.res_re    (res_re),
		.res_im    (res_im),
		.div_zero  (div_zero),
		.saturated (saturated)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(cau_pkg::LATENCY) done)
		else $error("request did not complete after the pipeline latency");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_zero |-> res_re == 16'sd0 && res_im == 16'sd0 && !saturated)
		else $error("divide by zero returned a nonzero result");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!front_st.vld && !iter_st.vld |=> !done)
		else $error("result strobe without a request in flight");

endmodule
